// File: src/tced_pkg.sv
package tced_pkg;

    // Block geometry.
    localparam int FRAMES_PER_BLOCK = 128;
    localparam int SLOTS            = 4;
    localparam int SAMPLE_W         = 16;
    localparam int SLOT_W           = 2;
    localparam int FRAME_W          = $clog2(FRAMES_PER_BLOCK);

    // Configuration register layout.
    localparam int MODE_W    = 3;
    localparam int CHAN_W    = 2;
    localparam int CFG_W     = 3;
    localparam int CFG_IDX_W = 1;

    typedef logic [SAMPLE_W-1:0]  sample_t;
    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [FRAME_W-1:0]   frame_t;
    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [CFG_W-1:0]     cfg_data_t;

    // Register indexes.
    localparam cfg_idx_t REG_STREAM_MODE      = 1'd0;
    localparam cfg_idx_t REG_SELECTED_CHANNEL = 1'd1;

    // Stream modes.
    localparam mode_t MODE_ONE_FULL = 3'd0;
    localparam mode_t MODE_ONE_HALF = 3'd1;
    localparam mode_t MODE_ALL_FULL = 3'd2;
    localparam mode_t MODE_ALL_SUM  = 3'd3;
    localparam mode_t MODE_BYTESWAP = 3'd4;

    // Frame indexes that carry the block end flag.
    localparam frame_t LAST_FRAME = FRAME_W'(FRAMES_PER_BLOCK - 1);
    localparam frame_t LAST_HALF  = FRAME_W'(((FRAMES_PER_BLOCK - 3) / 2) * 2);
    localparam frame_t LAST_PAIR  = FRAME_W'((FRAMES_PER_BLOCK / 2) * 2 - 1);

    localparam slot_t LAST_SLOT = SLOT_W'(SLOTS - 1);

    // Result beat.
    typedef struct packed {
        sample_t value;
        logic    block_end;
    } result_t;

endpackage

// File: src/tdm_channel_extract_decimate_unit.sv
// Four-slot TDM channel extractor and decimator. Samples arrive one beat at a
// time and each beat yields zero or one result beat, which is registered in
// the result or skid register. An input beat can be accepted in every cycle
// while in_stall is low: the whole per-sample decision (slot match, frame-pair
// sum, byte swap) is one short step into the result register, and a one-entry
// skid register keeps input acceptance going while a result waits on out_stall.
// in_stall rises only when both the result and skid registers are full.
// Configuration writes take effect on the next accepted sample and do not
// reset the slot and frame counters.
module tdm_channel_extract_decimate_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  tced_pkg::cfg_idx_t  cfg_index,
    input  tced_pkg::cfg_data_t cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  tced_pkg::sample_t   sample,
    output logic                out_valid,
    input  logic                out_stall,
    output tced_pkg::sample_t   out_sample,
    output logic                block_end
);
    import tced_pkg::*;

    mode_t   stream_mode_reg;
    slot_t   selected_channel_reg;
    slot_t   slot_count_reg;
    frame_t  frame_count_reg;
    sample_t pair_hold_reg [SLOTS];

    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;

    logic    in_take;
    logic    out_take;
    logic    odd_frame;
    logic    emit;
    result_t res;
    sample_t pair_sum;

    assign in_stall  = skid_valid_reg;
    assign in_take   = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;
    assign odd_frame = frame_count_reg[0];
    assign pair_sum  = pair_hold_reg[slot_count_reg] + sample;

    // Per-sample decision for the current mode.
    always_comb
    begin
        emit          = 1'b0;
        res.value     = sample;
        res.block_end = 1'b0;
        case (stream_mode_reg)
            MODE_ONE_FULL:
            begin
                emit          = (slot_count_reg == selected_channel_reg);
                res.block_end = (frame_count_reg == LAST_FRAME);
            end
            MODE_ONE_HALF:
            begin
                emit          = (slot_count_reg == selected_channel_reg) && !odd_frame
                                && (frame_count_reg <= FRAME_W'(FRAMES_PER_BLOCK - 3));
                res.block_end = (frame_count_reg == LAST_HALF);
            end
            MODE_ALL_FULL:
            begin
                emit          = 1'b1;
                res.block_end = (frame_count_reg == LAST_FRAME)
                                && (slot_count_reg == LAST_SLOT);
            end
            MODE_ALL_SUM:
            begin
                emit          = odd_frame;
                res.value     = pair_sum;
                res.block_end = (frame_count_reg == LAST_PAIR)
                                && (slot_count_reg == LAST_SLOT);
            end
            MODE_BYTESWAP:
            begin
                emit          = 1'b1;
                res.value     = {sample[7:0], sample[15:8]};
                res.block_end = (frame_count_reg == LAST_FRAME)
                                && (slot_count_reg == LAST_SLOT);
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_mode_reg      <= MODE_ONE_FULL;
            selected_channel_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_STREAM_MODE:      stream_mode_reg      <= cfg_data;
                REG_SELECTED_CHANNEL: selected_channel_reg <= cfg_data[CHAN_W-1:0];
                default:              ;
            endcase
        end
    end

    // Slot and frame counters, and the even-frame sample store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg  <= '0;
            frame_count_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                pair_hold_reg[i] <= '0;
            end
        end
        else if (in_take)
        begin
            if (!odd_frame)
            begin
                pair_hold_reg[slot_count_reg] <= sample;
            end
            slot_count_reg <= slot_count_reg + 1'b1;
            if (slot_count_reg == LAST_SLOT)
            begin
                if (frame_count_reg == LAST_FRAME)
                begin
                    frame_count_reg <= '0;
                end
                else
                begin
                    frame_count_reg <= frame_count_reg + 1'b1;
                end
            end
        end
    end

    // Result register with a one-entry skid behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_take)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= in_take && emit;
                end
            end
            else if (in_take && emit)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Result payloads.
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_take && emit)
            begin
                out_reg <= res;
            end
        end
        else if (in_take && emit)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_reg.value;
    assign block_end  = out_reg.block_end;

endmodule
